// File: src/bgf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgf_pkg: shared constants and types for the bilinear gradient fill
// Channel widths, register indexes, mix phase codes and the command word
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package bgf_pkg;

   localparam int CH_BITS       = 16;   // bits per color channel
   localparam int WT_BITS       = 16;   // bits per interpolation weight
   localparam int NUM_CH        = 4;    // red, green, blue, alpha
   localparam int COLOR_BITS    = CH_BITS * NUM_CH;
   localparam int MAX_W         = 4096;
   localparam int MAX_H         = 4096;
   localparam int POS_BITS      = 12;   // scan column / row
   localparam int SIZE_BITS     = 13;   // frame width / height registers
   localparam int PIX_BITS      = 24;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int CH_IDX_BITS   = $clog2(NUM_CH);
   localparam int DIV_CNT_BITS  = $clog2(WT_BITS);

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_TOP_LEFT     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_TOP_RIGHT    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOTTOM_LEFT  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOTTOM_RIGHT = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd5;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd320;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd240;

   // mix phases: even phases load p*(1-w), odd phases add q*w and retire
   localparam int PH_BITS = 3;
   localparam logic [PH_BITS-1:0] PH_TOP_A = 3'd0;
   localparam logic [PH_BITS-1:0] PH_TOP_B = 3'd1;
   localparam logic [PH_BITS-1:0] PH_BOT_A = 3'd2;
   localparam logic [PH_BITS-1:0] PH_BOT_B = 3'd3;
   localparam logic [PH_BITS-1:0] PH_OUT_A = 3'd4;
   localparam logic [PH_BITS-1:0] PH_OUT_B = 3'd5;

   typedef struct packed {
      logic                   start;     // word accepted: latch position
      logic                   div_step;  // one radix-2 weight divide step
      logic                   mix_step;  // one multiply-accumulate step
      logic [CH_IDX_BITS-1:0] chan;
      logic [PH_BITS-1:0]     phase;
      logic                   load_out;  // move result into output register
   } bgf_cmd_type;

endpackage
`default_nettype wire

// File: src/bgf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgf_req_if: request channel of the gradient fill
// Valid/ready channel carrying the restart flag.
// ----------------------------------------------------------------------------
interface bgf_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

// File: src/bgf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgf_rsp_if: pixel response channel of the gradient fill
// Valid/ready channel carrying one pixel position and its RGBA color.
// ----------------------------------------------------------------------------
interface bgf_rsp_if import bgf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] pixel_index;
   logic [POS_BITS-1:0] column;
   logic [POS_BITS-1:0] row;
   logic [CH_BITS-1:0]  red;
   logic [CH_BITS-1:0]  green;
   logic [CH_BITS-1:0]  blue;
   logic [CH_BITS-1:0]  alpha;
   logic                frame_end;

   modport source (output valid, output pixel_index, output column, output row,
                   output red, output green, output blue, output alpha,
                   output frame_end, input ready);
   modport sink   (input valid, input pixel_index, input column, input row,
                   input red, input green, input blue, input alpha,
                   input frame_end, output ready);
endinterface
`default_nettype wire

// File: src/bilinear_gradient_fill.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_gradient_fill: four-corner RGBA gradient raster source
// Each request word emits the next pixel of the frame in row-major order,
// colored by bilinear interpolation between the four corner colors.
//
//   channel   direction  handshake     word
//   req_chan  in         valid/ready   restart
//   rsp_chan  out        valid/ready   pixel_index, column, row, RGBA, frame_end
//   csr_*     in         write enable  register index, 64-bit data
//
// Each pixel runs through the accept cycle, 16 radix-2 divide steps for the two
// weights, 24 steps of the single shared multiply-accumulate (six per channel)
// and the load of the output register; no new request is taken before that load.
// The result sits in an output register; the next request is taken while it
// waits, and the sequencer stalls only when a new result is ready first.
// Reset (synchronous, active high) restores corner colors 0 and a 320x240 frame.
// ----------------------------------------------------------------------------
module bilinear_gradient_fill import bgf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   bgf_req_if.sink                       req_chan,
   bgf_rsp_if.source                     rsp_chan,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   bgf_cmd_type cmd;
   logic        req_ready;
   logic        rsp_valid;

   bgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   bgf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_restart     (req_chan.restart),
      .rsp_pixel_index (rsp_chan.pixel_index),
      .rsp_column      (rsp_chan.column),
      .rsp_row         (rsp_chan.row),
      .rsp_red         (rsp_chan.red),
      .rsp_green       (rsp_chan.green),
      .rsp_blue        (rsp_chan.blue),
      .rsp_alpha       (rsp_chan.alpha),
      .rsp_frame_end   (rsp_chan.frame_end)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule
`default_nettype wire

// File: src/bgf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgf_ctrl: sequencer of the gradient fill
// Steps each word through the weight divide, the shared multiply-accumulate
// and the output register; owns the channel handshakes.
// ----------------------------------------------------------------------------
module bgf_ctrl import bgf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output bgf_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_MIX  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PH_BITS-1:0]      phase_ff, phase_in;
   logic [CH_IDX_BITS-1:0]  chan_ff, chan_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      phase_in   = phase_ff;
      chan_in    = chan_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.chan   = chan_ff;
      cmd.phase  = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(WT_BITS - 1)) begin
               phase_in = PH_TOP_A;
               chan_in  = '0;
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            cmd.mix_step = 1'b1;
            if (phase_ff == PH_OUT_B) begin
               phase_in = PH_TOP_A;
               chan_in  = chan_ff + 1'b1;
               if (chan_ff == CH_IDX_BITS'(NUM_CH - 1))
                  state_in = S_OUT;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register valid: set on load, cleared when taken
   always_comb begin
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= PH_TOP_A;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // an accepted word always enters the divide phase next
   a_start_div: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DIV))
      else $error("accepted word did not start the divide");

   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while held");

   // a result appears only after the output state
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result valid raised outside output state");

   // the mix phase runs only after a full divide
   a_mix_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && state_in == S_MIX) |->
         (cnt_ff == DIV_CNT_BITS'(WT_BITS - 1)))
      else $error("divide left early");
`endif

endmodule
`default_nettype wire

// File: src/bgf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgf_dp: datapath of the gradient fill
// Configuration registers, scan position, radix-2 weight dividers, one
// shared 16x17 multiply-accumulate and the output register.
// ----------------------------------------------------------------------------
module bgf_dp import bgf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bgf_cmd_type              cmd,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                     req_restart,
   output logic [PIX_BITS-1:0]           rsp_pixel_index,
   output logic [POS_BITS-1:0]           rsp_column,
   output logic [POS_BITS-1:0]           rsp_row,
   output logic [CH_BITS-1:0]            rsp_red,
   output logic [CH_BITS-1:0]            rsp_green,
   output logic [CH_BITS-1:0]            rsp_blue,
   output logic [CH_BITS-1:0]            rsp_alpha,
   output logic                          rsp_frame_end
);

   localparam int PROD_BITS = CH_BITS + WT_BITS + 1;
   localparam logic [WT_BITS:0] ONE = (WT_BITS + 1)'(1) << WT_BITS;

   // configuration
   logic [COLOR_BITS-1:0] tl_ff, tr_ff, bl_ff, br_ff;
   logic [SIZE_BITS-1:0]  fw_ff, fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tl_ff <= '0;
         tr_ff <= '0;
         bl_ff <= '0;
         br_ff <= '0;
         fw_ff <= WIDTH_RESET;
         fh_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TOP_LEFT:     tl_ff <= csr_wdata[COLOR_BITS-1:0];
            REG_TOP_RIGHT:    tr_ff <= csr_wdata[COLOR_BITS-1:0];
            REG_BOTTOM_LEFT:  bl_ff <= csr_wdata[COLOR_BITS-1:0];
            REG_BOTTOM_RIGHT: br_ff <= csr_wdata[COLOR_BITS-1:0];
            REG_FRAME_WIDTH:  fw_ff <= csr_wdata[SIZE_BITS-1:0];
            REG_FRAME_HEIGHT: fh_ff <= csr_wdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size: zero acts as one, oversize clamps
   logic [SIZE_BITS-1:0] w_eff, h_eff;
   always_comb begin
      if (fw_ff == '0)
         w_eff = SIZE_BITS'(1);
      else if (fw_ff > SIZE_BITS'(MAX_W))
         w_eff = SIZE_BITS'(MAX_W);
      else
         w_eff = fw_ff;
      if (fh_ff == '0)
         h_eff = SIZE_BITS'(1);
      else if (fh_ff > SIZE_BITS'(MAX_H))
         h_eff = SIZE_BITS'(MAX_H);
      else
         h_eff = fh_ff;
   end

   // scan position: pos = pixel being built, scan = next pixel
   logic [POS_BITS-1:0] scan_col_ff, scan_row_ff;
   logic [POS_BITS-1:0] pos_col_ff, pos_row_ff;
   logic [POS_BITS-1:0] cur_col, cur_row, nxt_col, nxt_row;
   logic                wrap;

   always_comb begin
      wrap = req_restart || ({1'b0, scan_col_ff} >= w_eff) ||
             ({1'b0, scan_row_ff} >= h_eff);
      cur_col = wrap ? '0 : scan_col_ff;
      cur_row = wrap ? '0 : scan_row_ff;
      nxt_col = cur_col + 1'b1;
      nxt_row = cur_row;
      if (({1'b0, cur_col} + 1'b1) >= w_eff) begin
         nxt_col = '0;
         if (({1'b0, cur_row} + 1'b1) >= h_eff)
            nxt_row = '0;
         else
            nxt_row = cur_row + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff <= '0;
         scan_row_ff <= '0;
      end else if (cmd.start) begin
         scan_col_ff <= nxt_col;
         scan_row_ff <= nxt_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pos_col_ff <= cur_col;
         pos_row_ff <= cur_row;
      end
   end

   // weights: (pos << 16) / size, one quotient bit per step
   logic [SIZE_BITS-1:0] rem_x_ff, rem_y_ff;
   logic [WT_BITS-1:0]   wx_ff, wy_ff;
   logic [SIZE_BITS:0]   tx, ty;

   always_comb begin
      tx = {rem_x_ff, 1'b0};
      ty = {rem_y_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_x_ff <= {1'b0, cur_col};
         rem_y_ff <= {1'b0, cur_row};
         wx_ff    <= '0;
         wy_ff    <= '0;
      end else if (cmd.div_step) begin
         if (tx >= {1'b0, w_eff}) begin
            rem_x_ff <= SIZE_BITS'(tx - {1'b0, w_eff});
            wx_ff    <= {wx_ff[WT_BITS-2:0], 1'b1};
         end else begin
            rem_x_ff <= tx[SIZE_BITS-1:0];
            wx_ff    <= {wx_ff[WT_BITS-2:0], 1'b0};
         end
         if (ty >= {1'b0, h_eff}) begin
            rem_y_ff <= SIZE_BITS'(ty - {1'b0, h_eff});
            wy_ff    <= {wy_ff[WT_BITS-2:0], 1'b1};
         end else begin
            rem_y_ff <= ty[SIZE_BITS-1:0];
            wy_ff    <= {wy_ff[WT_BITS-2:0], 1'b0};
         end
      end
   end

   // pixel index, recomputed while the divide runs
   logic [PIX_BITS-1:0] pix_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_step)
         pix_ff <= PIX_BITS'(pos_row_ff * w_eff + {{SIZE_BITS{1'b0}}, pos_col_ff});
   end

   // shared multiply-accumulate: p*(1-w) on even phases, +q*w on odd
   logic [CH_BITS-1:0]   top_ff, bot_ff;
   logic [PROD_BITS-1:0] acc_ff;
   logic [CH_BITS-1:0]   mul_a;
   logic [WT_BITS:0]     mul_b;
   logic [WT_BITS-1:0]   wsel;
   logic [PROD_BITS-1:0] prod, sum;
   logic [CH_BITS-1:0]   mix_res;
   logic [NUM_CH-1:0][CH_BITS-1:0] color_ff;

   always_comb begin
      case (cmd.phase)
         PH_TOP_A: mul_a = tl_ff[cmd.chan*CH_BITS +: CH_BITS];
         PH_TOP_B: mul_a = tr_ff[cmd.chan*CH_BITS +: CH_BITS];
         PH_BOT_A: mul_a = bl_ff[cmd.chan*CH_BITS +: CH_BITS];
         PH_BOT_B: mul_a = br_ff[cmd.chan*CH_BITS +: CH_BITS];
         PH_OUT_A: mul_a = top_ff;
         PH_OUT_B: mul_a = bot_ff;
         default:  mul_a = '0;
      endcase
      wsel    = (cmd.phase == PH_OUT_A || cmd.phase == PH_OUT_B) ? wy_ff : wx_ff;
      mul_b   = cmd.phase[0] ? {1'b0, wsel} : (ONE - {1'b0, wsel});
      prod    = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      sum     = acc_ff + prod;
      mix_res = sum[WT_BITS +: CH_BITS];
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_step) begin
         if (!cmd.phase[0])
            acc_ff <= prod;
         case (cmd.phase)
            PH_TOP_B: top_ff <= mix_res;
            PH_BOT_B: bot_ff <= mix_res;
            PH_OUT_B: color_ff[cmd.chan] <= mix_res;
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_pixel_index <= pix_ff;
         rsp_column      <= pos_col_ff;
         rsp_row         <= pos_row_ff;
         rsp_red         <= color_ff[0];
         rsp_green       <= color_ff[1];
         rsp_blue        <= color_ff[2];
         rsp_alpha       <= color_ff[3];
         rsp_frame_end   <= ({1'b0, pos_col_ff} == w_eff - 1'b1) &&
                            ({1'b0, pos_row_ff} == h_eff - 1'b1);
      end
   end

endmodule
`default_nettype wire
